/* sv/rcddm_pkg.sv */
// shared constants, register codes and types for the differential drive mixer
`default_nettype none

package rcddm_pkg;

    // field widths
    localparam int PULSE_BITS      = 12;
    localparam int SPEED_BITS      = 10;
    localparam int SCALE_FRAC_BITS = 8;
    localparam int SCALE_BITS      = SCALE_FRAC_BITS + 2;

    // pulse limits in microseconds
    localparam int PULSE_MIN_US  = 1000;
    localparam int PULSE_MAX_US  = 2000;
    localparam int PULSE_SPAN_US = PULSE_MAX_US - PULSE_MIN_US;

    // offset of a clamped pulse above the minimum
    localparam int OFFS_BITS = $clog2(PULSE_SPAN_US + 1);

    // span of a mapping range (speed or scale), signed
    localparam int SPAN_BITS = (SPEED_BITS > SCALE_BITS ? SPEED_BITS : SCALE_BITS) + 1;
    localparam int PROD_BITS = OFFS_BITS + 1 + SPAN_BITS;
    localparam int MAG_BITS  = $clog2(PULSE_SPAN_US * (2 ** (SPAN_BITS - 1)) + 1);

    // division by the pulse span as a reciprocal multiply
    localparam int     DIV_SHIFT = MAG_BITS + OFFS_BITS;
    localparam longint DIV_MULT  = ((longint'(1) << DIV_SHIFT) + PULSE_SPAN_US - 1)
                                   / PULSE_SPAN_US;
    localparam int     MULT_BITS = $clog2(DIV_MULT + 1);
    localparam int     Q_BITS    = SPAN_BITS - 1;

    // speed times scale and the result after the fraction shift
    localparam int SPROD_BITS = SPEED_BITS + SCALE_BITS + 1;
    localparam int SC_BITS    = SPROD_BITS - SCALE_FRAC_BITS;
    localparam int SUM_BITS   = SC_BITS + 1;

    // stream packing
    localparam int IN_FIELD_BITS = 3 * PULSE_BITS;
    localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 2 * SPEED_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // configuration port
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 3;
    localparam int APB_ADDR_BITS = REG_IDX_BITS + 2;

    localparam logic [REG_IDX_BITS-1:0] REG_SPEED_LOW   = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_SPEED_HIGH  = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_NEUTRAL_LOW = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_NEUTRAL_HIGH = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_SCALE_LOW   = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_SCALE_HIGH  = 3'd5;

    // register reset values
    localparam logic signed [SPEED_BITS-1:0] RST_SPEED_LOW    = -10'sd255;
    localparam logic signed [SPEED_BITS-1:0] RST_SPEED_HIGH   = 10'sd255;
    localparam logic [PULSE_BITS-1:0]        RST_NEUTRAL_LOW  = 12'd1450;
    localparam logic [PULSE_BITS-1:0]        RST_NEUTRAL_HIGH = 12'd1550;
    localparam logic [SCALE_BITS-1:0]        RST_SCALE_LOW    = 10'd128;
    localparam logic [SCALE_BITS-1:0]        RST_SCALE_HIGH   = 10'd256;

    // channel order inside the pipeline
    localparam int NCH    = 3;
    localparam int CH_TRN = 0;
    localparam int CH_MOV = 1;
    localparam int CH_THR = 2;

    // pipeline depth
    localparam int NSTG = 7;

    typedef struct packed {
        logic signed [SPEED_BITS-1:0] speed_low;
        logic signed [SPEED_BITS-1:0] speed_high;
        logic [PULSE_BITS-1:0]        neutral_low;
        logic [PULSE_BITS-1:0]        neutral_high;
        logic [SCALE_BITS-1:0]        scale_low;
        logic [SCALE_BITS-1:0]        scale_high;
    } t_cfg;

endpackage

`default_nettype wire

/* sv/rc_differential_drive_mixer_top.sv */
// differential drive mixer: rc pulses to left and right wheel speeds
// throughput: one item per cycle; each of the seven stages holds its item only while
// the stage after it is full, so a stall on the output side backs up stage by stage
// reset: synchronous active low; clears the stage valid bits and loads the register defaults
// configuration is read straight from the registers and is meant to change only when idle
`default_nettype none

module rc_differential_drive_mixer_top
    import rcddm_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // input stream
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [IN_DATA_BITS-1:0]   s_axis_tdata,  // turn_pulse, move_pulse, throttle_pulse, zero pad
    input  wire logic                      s_axis_tuser,  // signals_valid
    // output stream
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic [OUT_DATA_BITS-1:0]       m_axis_tdata,  // left_speed, right_speed, zero pad
    output logic                           m_axis_tuser,  // drive_enabled
    // register port
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [APB_DATA_BITS-1:0]  pwdata,
    output logic [APB_DATA_BITS-1:0]       prdata,
    output logic                           pready
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    t_cfg                    r_cfg;
    logic [REG_IDX_BITS-1:0] w_idx;
    logic                    w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[APB_ADDR_BITS-1:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_low    <= RST_SPEED_LOW;
            r_cfg.speed_high   <= RST_SPEED_HIGH;
            r_cfg.neutral_low  <= RST_NEUTRAL_LOW;
            r_cfg.neutral_high <= RST_NEUTRAL_HIGH;
            r_cfg.scale_low    <= RST_SCALE_LOW;
            r_cfg.scale_high   <= RST_SCALE_HIGH;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_SPEED_LOW:    r_cfg.speed_low    <= pwdata[SPEED_BITS-1:0];
                REG_SPEED_HIGH:   r_cfg.speed_high   <= pwdata[SPEED_BITS-1:0];
                REG_NEUTRAL_LOW:  r_cfg.neutral_low  <= pwdata[PULSE_BITS-1:0];
                REG_NEUTRAL_HIGH: r_cfg.neutral_high <= pwdata[PULSE_BITS-1:0];
                REG_SCALE_LOW:    r_cfg.scale_low    <= pwdata[SCALE_BITS-1:0];
                REG_SCALE_HIGH:   r_cfg.scale_high   <= pwdata[SCALE_BITS-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_SPEED_LOW:
                prdata = APB_DATA_BITS'(unsigned'(r_cfg.speed_low));
            REG_SPEED_HIGH:
                prdata = APB_DATA_BITS'(unsigned'(r_cfg.speed_high));
            REG_NEUTRAL_LOW:  prdata = APB_DATA_BITS'(r_cfg.neutral_low);
            REG_NEUTRAL_HIGH: prdata = APB_DATA_BITS'(r_cfg.neutral_high);
            REG_SCALE_LOW:    prdata = APB_DATA_BITS'(r_cfg.scale_low);
            REG_SCALE_HIGH:   prdata = APB_DATA_BITS'(r_cfg.scale_high);
            default:          prdata = '0;
        endcase
    end

    // spans of the two mappings, registered off the configuration
    logic signed [SPAN_BITS-1:0] r_spd_span;
    logic signed [SPAN_BITS-1:0] r_scl_span;

    always_ff @(posedge i_clk) begin
        r_spd_span <= SPAN_BITS'(r_cfg.speed_high) - SPAN_BITS'(r_cfg.speed_low);
        r_scl_span <= $signed(SPAN_BITS'(r_cfg.scale_high))
                    - $signed(SPAN_BITS'(r_cfg.scale_low));
    end

    // ------------------------------------------------------------------
    // stage handshake: a stage loads when it is empty or the next one loads
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign s_axis_tready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: clamp pulses to the 1000..2000 us window, neutral band test
    // ------------------------------------------------------------------
    logic [PULSE_BITS-1:0] w_pulse [NCH];
    logic [OFFS_BITS-1:0]  n_s1_p  [NCH];
    logic [1:0]            n_s1_neu;

    logic [OFFS_BITS-1:0]  r_s1_p  [NCH];
    logic [1:0]            r_s1_neu;
    logic                  r_s1_sv;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            w_pulse[c] = s_axis_tdata[c*PULSE_BITS +: PULSE_BITS];
            if (w_pulse[c] < PULSE_BITS'(PULSE_MIN_US)) begin
                n_s1_p[c] = '0;
            end else if (w_pulse[c] > PULSE_BITS'(PULSE_MAX_US)) begin
                n_s1_p[c] = OFFS_BITS'(PULSE_SPAN_US);
            end else begin
                n_s1_p[c] = OFFS_BITS'(w_pulse[c] - PULSE_BITS'(PULSE_MIN_US));
            end
        end
        // raw pulse against the band; an inverted band never matches
        for (int c = 0; c < 2; c++) begin
            n_s1_neu[c] = (w_pulse[c] >= r_cfg.neutral_low)
                       && (w_pulse[c] <= r_cfg.neutral_high);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s1_p   <= n_s1_p;
            r_s1_neu <= n_s1_neu;
            r_s1_sv  <= s_axis_tuser;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: offset times span, split into magnitude and sign
    // ------------------------------------------------------------------
    logic signed [PROD_BITS-1:0] w_s2_prod [NCH];
    logic [MAG_BITS-1:0]         n_s2_mag  [NCH];
    logic [NCH-1:0]              n_s2_neg;

    logic [MAG_BITS-1:0]         r_s2_mag  [NCH];
    logic [NCH-1:0]              r_s2_neg;
    logic [1:0]                  r_s2_neu;
    logic                        r_s2_sv;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            w_s2_prod[c] = $signed({1'b0, r_s1_p[c]})
                         * ((c == CH_THR) ? r_scl_span : r_spd_span);
            n_s2_neg[c]  = w_s2_prod[c][PROD_BITS-1];
            n_s2_mag[c]  = n_s2_neg[c] ? MAG_BITS'(-w_s2_prod[c])
                                       : MAG_BITS'(w_s2_prod[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s2_mag <= n_s2_mag;
            r_s2_neg <= n_s2_neg;
            r_s2_neu <= r_s1_neu;
            r_s2_sv  <= r_s1_sv;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: magnitude divided by the pulse span, reciprocal multiply
    // exact over the whole magnitude range, so truncation toward zero holds
    // ------------------------------------------------------------------
    logic [MAG_BITS+MULT_BITS-1:0] w_s3_prod [NCH];
    logic [Q_BITS-1:0]             n_s3_q    [NCH];

    logic [Q_BITS-1:0]             r_s3_q    [NCH];
    logic [NCH-1:0]                r_s3_neg;
    logic [1:0]                    r_s3_neu;
    logic                          r_s3_sv;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            w_s3_prod[c] = (MAG_BITS+MULT_BITS)'(r_s2_mag[c])
                         * (MAG_BITS+MULT_BITS)'(DIV_MULT);
            n_s3_q[c]    = w_s3_prod[c][DIV_SHIFT +: Q_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s3_q   <= n_s3_q;
            r_s3_neg <= r_s2_neg;
            r_s3_neu <= r_s2_neu;
            r_s3_sv  <= r_s2_sv;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: restore sign, add the range base, zero neutral channels
    // ------------------------------------------------------------------
    logic signed [Q_BITS:0]        w_s4_sq [NCH];
    logic signed [SPEED_BITS+1:0]  w_s4_spd_sum [2];
    logic signed [SCALE_BITS+1:0]  w_s4_scl_sum;
    logic signed [SPEED_BITS-1:0]  n_s4_spd [2];

    logic signed [SPEED_BITS-1:0]  r_s4_spd [2];
    logic [SCALE_BITS-1:0]         r_s4_scale;
    logic                          r_s4_sv;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            w_s4_sq[c] = r_s3_neg[c] ? -$signed({1'b0, r_s3_q[c]})
                                     :  $signed({1'b0, r_s3_q[c]});
        end
        for (int c = 0; c < 2; c++) begin
            w_s4_spd_sum[c] = (SPEED_BITS+2)'(r_cfg.speed_low) + (SPEED_BITS+2)'(w_s4_sq[c]);
            n_s4_spd[c]     = r_s3_neu[c] ? '0 : SPEED_BITS'(w_s4_spd_sum[c]);
        end
        w_s4_scl_sum = $signed((SCALE_BITS+2)'(r_cfg.scale_low))
                     + (SCALE_BITS+2)'(w_s4_sq[CH_THR]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_s4_spd   <= n_s4_spd;
            r_s4_scale <= SCALE_BITS'(w_s4_scl_sum);
            r_s4_sv    <= r_s3_sv;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: speed times throttle scale
    // ------------------------------------------------------------------
    logic signed [SPROD_BITS-1:0] n_s5_prod [2];
    logic signed [SPROD_BITS-1:0] r_s5_prod [2];
    logic                         r_s5_sv;

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            n_s5_prod[c] = SPROD_BITS'(r_s4_spd[c] * $signed({1'b0, r_s4_scale}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_s5_prod <= n_s5_prod;
            r_s5_sv   <= r_s4_sv;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: drop the fraction bits, truncating toward zero
    // ------------------------------------------------------------------
    logic signed [SPROD_BITS-1:0] w_s6_adj [2];
    logic signed [SC_BITS-1:0]    n_s6_sc  [2];
    logic signed [SC_BITS-1:0]    r_s6_sc  [2];
    logic                         r_s6_sv;

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            // negative values get the fraction mask added before the shift
            w_s6_adj[c] = r_s5_prod[c]
                        + (r_s5_prod[c][SPROD_BITS-1]
                           ? SPROD_BITS'((1 << SCALE_FRAC_BITS) - 1) : '0);
            n_s6_sc[c]  = w_s6_adj[c][SPROD_BITS-1:SCALE_FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_s6_sc <= n_s6_sc;
            r_s6_sv <= r_s5_sv;
        end
    end

    // ------------------------------------------------------------------
    // stage 7: mix, clamp floor first then ceiling, output register
    // ------------------------------------------------------------------
    logic signed [SUM_BITS-1:0]   w_s7_mix [2];
    logic signed [SUM_BITS-1:0]   w_s7_lo;
    logic signed [SUM_BITS-1:0]   w_s7_hi;
    logic signed [SUM_BITS-1:0]   w_s7_clp [2];
    logic signed [SPEED_BITS-1:0] n_out_spd [2];

    logic signed [SPEED_BITS-1:0] r_out_left;
    logic signed [SPEED_BITS-1:0] r_out_right;
    logic                         r_out_en;

    always_comb begin
        w_s7_lo     = SUM_BITS'(r_cfg.speed_low);
        w_s7_hi     = SUM_BITS'(r_cfg.speed_high);
        w_s7_mix[0] = SUM_BITS'(r_s6_sc[CH_TRN]) - SUM_BITS'(r_s6_sc[CH_MOV]);
        w_s7_mix[1] = SUM_BITS'(r_s6_sc[CH_TRN]) + SUM_BITS'(r_s6_sc[CH_MOV]);
        for (int c = 0; c < 2; c++) begin
            priority if (w_s7_mix[c] < w_s7_lo) begin
                w_s7_clp[c] = w_s7_lo;
            end else if (w_s7_mix[c] > w_s7_hi) begin
                w_s7_clp[c] = w_s7_hi;
            end else begin
                w_s7_clp[c] = w_s7_mix[c];
            end
            // invalid receiver signals stop both wheels
            n_out_spd[c] = r_s6_sv ? SPEED_BITS'(w_s7_clp[c]) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_out_left  <= n_out_spd[0];
            r_out_right <= n_out_spd[1];
            r_out_en    <= r_s6_sv;
        end
    end

    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tuser  = r_out_en;
    assign m_axis_tdata  = OUT_DATA_BITS'({r_out_right, r_out_left});

`ifndef SYNTHESIS

    // a full pipe only pushes back when the output is held
    a_backpressure_source: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready)
    ) else $error("input stalled without an output stall");

    // a stopped drive carries zero speeds
    a_disabled_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0)
    ) else $error("disabled item carries nonzero speeds");

    // an output taken with nothing behind it leaves the output empty
    a_drain: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !r_vld[NSTG-2]) |=> !m_axis_tvalid
    ) else $error("item repeated on the output");

`endif

endmodule

`default_nettype wire

/* test/tb_rc_differential_drive_mixer_top.sv */
// testbench for the differential drive mixer: random and directed items against a predictor
`default_nettype none

module tb_rc_differential_drive_mixer_top;
    import rcddm_pkg::*;

    typedef logic [PULSE_BITS-1:0]        t_pulse;
    typedef logic signed [SPEED_BITS-1:0] t_speed;
    typedef logic [SCALE_BITS-1:0]        t_scale;

    typedef struct {
        t_speed left;
        t_speed right;
        logic   enabled;
    } t_wheel_result;

    // register index with no register behind it, writes must be dropped
    localparam logic [REG_IDX_BITS-1:0] REG_SPARE = 3'd6;

    // generous bound on the whole run
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PER_PHASE = 93;

    // holds a copy of the registers and the queue of speeds still owed by the block
    class t_wheel_speed_tracker;
        t_speed spd_lo;
        t_speed spd_hi;
        t_pulse neu_lo;
        t_pulse neu_hi;
        t_scale scl_lo;
        t_scale scl_hi;
        t_wheel_result pending[$];
        int unsigned failures;

        function new();
            spd_lo   = RST_SPEED_LOW;
            spd_hi   = RST_SPEED_HIGH;
            neu_lo   = RST_NEUTRAL_LOW;
            neu_hi   = RST_NEUTRAL_HIGH;
            scl_lo   = RST_SCALE_LOW;
            scl_hi   = RST_SCALE_HIGH;
            failures = 0;
        endfunction

        function void set_register(logic [REG_IDX_BITS-1:0] idx, logic [APB_DATA_BITS-1:0] value);
            case (idx)
                REG_SPEED_LOW:    spd_lo = value[SPEED_BITS-1:0];
                REG_SPEED_HIGH:   spd_hi = value[SPEED_BITS-1:0];
                REG_NEUTRAL_LOW:  neu_lo = value[PULSE_BITS-1:0];
                REG_NEUTRAL_HIGH: neu_hi = value[PULSE_BITS-1:0];
                REG_SCALE_LOW:    scl_lo = value[SCALE_BITS-1:0];
                REG_SCALE_HIGH:   scl_hi = value[SCALE_BITS-1:0];
                default: ;
            endcase
        endfunction

        // clamped pulse as an offset above the minimum, 0..span
        function longint pulse_offset(t_pulse p);
            if (p < PULSE_MIN_US) return 0;
            if (p > PULSE_MAX_US) return PULSE_SPAN_US;
            return longint'(p) - PULSE_MIN_US;
        endfunction

        // linear speed map, zero inside the deadband (empty when the band is inverted)
        function longint channel_speed(t_pulse p);
            longint lo;
            longint hi;
            lo = longint'(spd_lo);
            hi = longint'(spd_hi);
            if (p >= neu_lo && p <= neu_hi) return 0;
            return pulse_offset(p) * (hi - lo) / PULSE_SPAN_US + lo;
        endfunction

        // floor tested first, then ceiling
        function longint clamp_speed(longint v);
            if (v < longint'(spd_lo)) return longint'(spd_lo);
            if (v > longint'(spd_hi)) return longint'(spd_hi);
            return v;
        endfunction

        function t_wheel_result mix_speeds(t_pulse turn_p, t_pulse move_p, t_pulse thr_p,
                                           logic valid);
            t_wheel_result r;
            longint turn;
            longint move;
            longint scale;
            longint one;
            longint left;
            longint right;
            if (!valid) begin
                r.left    = '0;
                r.right   = '0;
                r.enabled = 1'b0;
                return r;
            end
            turn  = channel_speed(turn_p);
            move  = channel_speed(move_p);
            scale = longint'(scl_lo)
                  + pulse_offset(thr_p) * (longint'(scl_hi) - longint'(scl_lo)) / PULSE_SPAN_US;
            one   = longint'(1) << SCALE_FRAC_BITS;
            // signed division truncates toward zero
            turn  = turn * scale / one;
            move  = move * scale / one;
            left  = clamp_speed(turn - move);
            right = clamp_speed(turn + move);
            r.left    = left[SPEED_BITS-1:0];
            r.right   = right[SPEED_BITS-1:0];
            r.enabled = 1'b1;
            return r;
        endfunction

        function void note_sample(logic [IN_DATA_BITS-1:0] data, logic valid);
            pending.push_back(mix_speeds(data[PULSE_BITS-1:0],
                                         data[2*PULSE_BITS-1:PULSE_BITS],
                                         data[3*PULSE_BITS-1:2*PULSE_BITS], valid));
        endfunction

        function void check_speeds(logic [OUT_DATA_BITS-1:0] data, logic enabled);
            t_wheel_result want;
            t_speed got_left;
            t_speed got_right;
            if (pending.size() == 0) begin
                $error("result item with no expected speeds waiting");
                failures++;
                return;
            end
            want      = pending.pop_front();
            got_left  = data[SPEED_BITS-1:0];
            got_right = data[2*SPEED_BITS-1:SPEED_BITS];
            if (got_left !== want.left) begin
                $error("left_speed: expected %0d, got %0d", want.left, got_left);
                failures++;
            end
            if (got_right !== want.right) begin
                $error("right_speed: expected %0d, got %0d", want.right, got_right);
                failures++;
            end
            if (enabled !== want.enabled) begin
                $error("drive_enabled: expected %0d, got %0d", want.enabled, enabled);
                failures++;
            end
        endfunction
    endclass

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // input stream, driven at the rising edge
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;  // turn_pulse, move_pulse, throttle_pulse, zero pad
    logic                     s_axis_tuser  = 1'b0; // signals_valid

    // output stream
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;  // left_speed, right_speed, zero pad
    logic                     m_axis_tuser;  // drive_enabled

    // register port
    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr   = '0;
    logic [APB_DATA_BITS-1:0] pwdata  = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    // receiver stall pattern state
    int unsigned rx_mode = 0;
    int unsigned rx_left = 0;
    int unsigned cycle_count = 0;

    t_wheel_speed_tracker tracker = new();

    always #4 i_clk = ~i_clk;

    rc_differential_drive_mixer_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // both handshakes sampled at the edge with their pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            tracker.note_sample(s_axis_tdata, s_axis_tuser);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tracker.check_speeds(m_axis_tdata, m_axis_tuser);
        end
    end

    // receiver: stretches of always ready, coin toss, heavy stall and light stall
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(4, 48);
        end else begin
            rx_left = rx_left - 1;
        end
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 1) == 1);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // pulse picker: out of range both ways, range edges, deadband edges, in-range values and anything at all
    function automatic t_pulse pick_pulse();
        int unsigned sel;
        int v;
        sel = $urandom_range(0, 9);
        case (sel)
            0: v = $urandom_range(0, PULSE_MIN_US - 1);
            1: v = $urandom_range(PULSE_MAX_US + 1, 4095);
            2: v = ($urandom_range(0, 1) == 1) ? PULSE_MAX_US : PULSE_MIN_US;
            3: v = int'(tracker.neu_lo) + int'($urandom_range(0, 2)) - 1;
            4: v = int'(tracker.neu_hi) + int'($urandom_range(0, 2)) - 1;
            5: v = $urandom_range(0, 4095);
            default: v = $urandom_range(PULSE_MIN_US, PULSE_MAX_US);
        endcase
        return t_pulse'(v);
    endfunction

    // present one item and hold it until the block takes it
    task automatic send_sample(input t_pulse turn_p, input t_pulse move_p, input t_pulse thr_p,
                               input logic valid);
        s_axis_tdata  <= IN_DATA_BITS'({thr_p, move_p, turn_p});
        s_axis_tuser  <= valid;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // register write: setup then access; psel stays up across back-to-back writes
    task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.set_register(idx, value);
    endtask

    task automatic configure(input int spd_lo, input int spd_hi, input int neu_lo,
                             input int neu_hi, input int scl_lo, input int scl_hi);
        write_reg(REG_SPEED_LOW, spd_lo);
        write_reg(REG_SPEED_HIGH, spd_hi);
        write_reg(REG_NEUTRAL_LOW, neu_lo);
        write_reg(REG_NEUTRAL_HIGH, neu_hi);
        write_reg(REG_SCALE_LOW, scl_lo);
        write_reg(REG_SCALE_HIGH, scl_hi);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // bursts of random length with random gaps, about a quarter of bursts run straight on
    task automatic send_random(input int count);
        int left_n;
        int unsigned burst;
        int unsigned gap;
        left_n = count;
        while (left_n > 0) begin
            burst = $urandom_range(1, 24);
            gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            while (burst > 0 && left_n > 0) begin
                send_sample(pick_pulse(), pick_pulse(), pick_pulse(), $urandom_range(0, 9) != 0);
                burst--;
                left_n--;
            end
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // wait for every owed result, then let the pipeline settle
    task automatic drain();
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (NSTG + 2) @(posedge i_clk);
    endtask

    // field extremes and special cases at the reset settings (deadband 1450..1550)
    task automatic send_directed();
        send_sample(12'd4095, 12'd4095, 12'd4095, 1'b0);  // invalid signals
        send_sample(12'd0, 12'd0, 12'd0, 1'b1);
        send_sample(12'd4095, 12'd4095, 12'd4095, 1'b1);
        send_sample(12'd1000, 12'd1000, 12'd1000, 1'b1);
        send_sample(12'd2000, 12'd2000, 12'd2000, 1'b1);
        send_sample(12'd999, 12'd2001, 12'd1500, 1'b1);
        send_sample(12'd1449, 12'd1450, 12'd2000, 1'b1);  // deadband lower edge
        send_sample(12'd1550, 12'd1551, 12'd1000, 1'b1);  // deadband upper edge
        send_sample(12'd2000, 12'd1000, 12'd2000, 1'b1);  // left saturates high
        send_sample(12'd1000, 12'd2000, 12'd2000, 1'b1);
        send_sample(12'd1750, 12'd1250, 12'd1333, 1'b1);
        send_sample(12'hAAA, 12'h555, 12'hAAA, 1'b1);
        send_sample(12'h555, 12'hAAA, 12'h555, 1'b1);
        send_sample(12'd1500, 12'd1500, 12'd1500, 1'b1);  // both neutral
        send_sample(12'd1234, 12'd1876, 12'd0, 1'b0);
        send_sample(12'd1001, 12'd1999, 12'd1999, 1'b1);
        send_sample(12'd1600, 12'd1600, 12'd4095, 1'b1);
        send_sample(12'd1300, 12'd1700, 12'd1, 1'b1);
        s_axis_tvalid <= 1'b0;
    endtask

    // timeout watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings
        send_directed();
        send_random(RANDOM_PER_PHASE);
        drain();

        // widest speed range, single-point deadband, full double scale
        configure(-511, 511, 1500, 1500, 512, 512);
        send_random(RANDOM_PER_PHASE);
        drain();

        // inverted speed range, inverted deadband, falling scale
        configure(200, -300, 1600, 1400, 512, 0);
        send_random(RANDOM_PER_PHASE);
        drain();

        // degenerate range at the floor, deadband below the pulse range, scale rising from zero
        configure(-511, -511, 0, 999, 0, 512);
        send_random(RANDOM_PER_PHASE);
        drain();

        // spare index must be ignored, then a one-sided range with unity scale
        write_reg(REG_SPARE, 32'h0000_0155);
        configure(0, 511, 2000, 2100, 256, 256);
        send_random(RANDOM_PER_PHASE);
        drain();

        // two random settings across the legal ranges
        repeat (2) begin
            configure(int'($urandom_range(0, 1022)) - 511, int'($urandom_range(0, 1022)) - 511,
                      $urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 512), $urandom_range(0, 512));
            send_random(RANDOM_PER_PHASE);
            drain();
        end

        if (tracker.failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
